// ===== hw/rtl/slcp_pkg.sv =====
// Serial line command parser: shared types, phase codes and keyword tables.
// No dependencies.
package slcp_pkg;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_GOT_K    = 4'd1,
    PH_GOT_C    = 4'd2,
    PH_HEX_HI   = 4'd3,
    PH_HEX_LO   = 4'd4,
    PH_KEY_TAIL = 4'd5,
    PH_CMD      = 4'd6,
    PH_REJECT   = 4'd7,
    PH_DONE_NO  = 4'd8,
    PH_DONE_KEY = 4'd9,
    PH_DONE_CMD = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_CMD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_AUDIO   = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_TOUCH   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] line_kind;
    logic [7:0] key_state;
    logic [1:0] command_code;
  } result_t;

  localparam int NUM_KW = 4;
  localparam logic [7:0] CHR_K     = 8'h4B;
  localparam logic [7:0] CHR_C     = 8'h43;
  localparam logic [7:0] CHR_COLON = 8'h3A;

  // Keywords, first character in the top byte.
  localparam logic [63:0] KW_AUDIO   = {"AUDIO", 24'h0};
  localparam logic [63:0] KW_DISPLAY = {"DISPLAY", 8'h0};
  localparam logic [63:0] KW_TOUCH   = "TOUCHCAL";
  localparam logic [63:0] KW_TCAL    = {"TCAL", 32'h0};

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [63:0] s;
    logic [2:0]  idx;
    case (k)
      2'd0:    s = KW_AUDIO;
      2'd1:    s = KW_DISPLAY;
      2'd2:    s = KW_TOUCH;
      default: s = KW_TCAL;
    endcase
    idx = 3'd7 - p;
    return s[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0:    return 4'd5;
      2'd1:    return 4'd7;
      2'd2:    return 4'd8;
      default: return 4'd4;
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
      return {1'b1, v[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
      return {1'b1, v[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== hw/rtl/serial_line_command_parser_top.sv =====
// Serial line command parser, top level: stream ports, parser and result buffer.
// Depends on slcp_pkg, slcp_parser and slcp_out_buf.
//
// One line byte per cycle is accepted; tlast on the input marks the end of the
// line and carries no character. Each end-of-line request produces exactly one
// result, registered through a two-entry output buffer, so input keeps
// flowing while a result waits; input stalls only once two results are waiting.
// Results: tuser holds the line kind (0 unrecognised, 1 key state, 2 command),
// tdata the parsed hex byte and command code.
module serial_line_command_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] key_state, [9:8] command_code, [15:10] zero
  output logic [1:0]  m_axis_tuser    // [1:0] line_kind
);

  logic              take;
  logic              res_valid;
  logic              can_take;
  slcp_pkg::result_t res;
  slcp_pkg::result_t out_res;

  assign s_axis_tready = can_take;
  assign take          = s_axis_tvalid && can_take;

  slcp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .char_byte   (s_axis_tdata),
    .end_of_line (s_axis_tlast),
    .res_valid   (res_valid),
    .res         (res)
  );

  slcp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.command_code, out_res.key_state};
  assign m_axis_tuser = out_res.line_kind;

endmodule

// ===== hw/rtl/slcp_parser.sv =====
// Serial line command parser: per-byte phase state machine and verdict logic.
// Depends on slcp_pkg.
module slcp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           char_byte,
  input  logic                 end_of_line,
  output logic                 res_valid,
  output slcp_pkg::result_t    res
);

  slcp_pkg::phase_t phase, phase_next;
  logic [7:0] hex_acc, hex_acc_next;
  logic [3:0] kw_pos, kw_pos_next;
  logic [3:0] kw_cand, kw_cand_next;
  logic       trail_seen, trail_seen_next;

  slcp_pkg::phase_t settled_phase;
  logic [3:0] settled_cand;
  logic [3:0] hit;
  logic [3:0] live;
  logic [4:0] hd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= slcp_pkg::PH_LEAD;
      hex_acc    <= 8'd0;
      kw_pos     <= 4'd0;
      kw_cand    <= 4'hF;
      trail_seen <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      hex_acc    <= hex_acc_next;
      kw_pos     <= kw_pos_next;
      kw_cand    <= kw_cand_next;
      trail_seen <= trail_seen_next;
    end
  end

  // Verdict from the bytes seen so far
  always_comb begin
    for (int i = 0; i < slcp_pkg::NUM_KW; i++) begin
      hit[i] = kw_cand[i] && (slcp_pkg::kw_len(2'(i)) == kw_pos);
      live[i] = kw_cand[i] && (kw_pos < slcp_pkg::kw_len(2'(i))) &&
                (slcp_pkg::kw_char(2'(i), kw_pos[2:0]) == char_byte);
    end
    settled_cand = kw_cand;
    case (phase)
      slcp_pkg::PH_KEY_TAIL: settled_phase = slcp_pkg::PH_DONE_KEY;
      slcp_pkg::PH_CMD: begin
        if (hit != 4'd0) begin
          settled_phase = slcp_pkg::PH_DONE_CMD;
          settled_cand  = hit;
        end else begin
          settled_phase = slcp_pkg::PH_DONE_NO;
        end
      end
      slcp_pkg::PH_DONE_NO, slcp_pkg::PH_DONE_KEY, slcp_pkg::PH_DONE_CMD:
        settled_phase = phase;
      default: settled_phase = slcp_pkg::PH_DONE_NO;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    hex_acc_next    = hex_acc;
    kw_pos_next     = kw_pos;
    kw_cand_next    = kw_cand;
    trail_seen_next = trail_seen;
    hd              = slcp_pkg::hex_digit(char_byte);
    res_valid       = take && end_of_line;
    res.line_kind   = slcp_pkg::KIND_NONE;
    res.key_state   = 8'd0;
    res.command_code = slcp_pkg::CMD_NONE;

    if (end_of_line) begin
      if (settled_phase == slcp_pkg::PH_DONE_KEY) begin
        res.line_kind = slcp_pkg::KIND_KEY;
        res.key_state = hex_acc;
      end else if (settled_phase == slcp_pkg::PH_DONE_CMD) begin
        res.line_kind = slcp_pkg::KIND_CMD;
        if (settled_cand[0]) res.command_code = slcp_pkg::CMD_AUDIO;
        else if (settled_cand[1]) res.command_code = slcp_pkg::CMD_DISPLAY;
        else if (settled_cand[2] || settled_cand[3]) res.command_code = slcp_pkg::CMD_TOUCH;
        else res.command_code = slcp_pkg::CMD_NONE;
      end
      phase_next      = slcp_pkg::PH_LEAD;
      hex_acc_next    = 8'd0;
      kw_pos_next     = 4'd0;
      kw_cand_next    = 4'hF;
      trail_seen_next = 1'b0;
    end else if (phase >= slcp_pkg::PH_DONE_NO) begin
      phase_next = phase;
    end else if (char_byte == 8'd0) begin
      phase_next   = settled_phase;
      kw_cand_next = settled_cand;
    end else begin
      case (phase)
        slcp_pkg::PH_LEAD: begin
          if (!slcp_pkg::is_ws(char_byte)) begin
            if (char_byte == slcp_pkg::CHR_K) phase_next = slcp_pkg::PH_GOT_K;
            else if (char_byte == slcp_pkg::CHR_C) phase_next = slcp_pkg::PH_GOT_C;
            else phase_next = slcp_pkg::PH_REJECT;
          end
        end
        slcp_pkg::PH_GOT_K:
          phase_next = (char_byte == slcp_pkg::CHR_COLON) ? slcp_pkg::PH_HEX_HI
                                                          : slcp_pkg::PH_REJECT;
        slcp_pkg::PH_GOT_C: begin
          if (char_byte == slcp_pkg::CHR_COLON) begin
            phase_next      = slcp_pkg::PH_CMD;
            kw_pos_next     = 4'd0;
            kw_cand_next    = 4'hF;
            trail_seen_next = 1'b0;
          end else begin
            phase_next = slcp_pkg::PH_REJECT;
          end
        end
        slcp_pkg::PH_HEX_HI: begin
          if (hd[4]) begin
            hex_acc_next = {4'd0, hd[3:0]};
            phase_next   = slcp_pkg::PH_HEX_LO;
          end else begin
            phase_next = slcp_pkg::PH_REJECT;
          end
        end
        slcp_pkg::PH_HEX_LO: begin
          if (hd[4]) begin
            hex_acc_next = {hex_acc[3:0], hd[3:0]};
            phase_next   = slcp_pkg::PH_KEY_TAIL;
          end else begin
            phase_next = slcp_pkg::PH_REJECT;
          end
        end
        slcp_pkg::PH_KEY_TAIL:
          if (!slcp_pkg::is_ws(char_byte)) phase_next = slcp_pkg::PH_REJECT;
        slcp_pkg::PH_CMD: begin
          if (slcp_pkg::is_ws(char_byte)) begin
            trail_seen_next = 1'b1;
          end else if (trail_seen) begin
            phase_next = slcp_pkg::PH_REJECT;
          end else begin
            kw_cand_next = live;
            if (kw_pos != 4'hF) kw_pos_next = kw_pos + 4'd1;
          end
        end
        default: phase_next = slcp_pkg::PH_REJECT;
      endcase
    end
  end

  a_eol_resets: assert property (@(posedge clk) disable iff (rst)
    take && end_of_line |=> phase == slcp_pkg::PH_LEAD && kw_cand == 4'hF)
    else $error("line state not cleared after end of line");
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    take && !end_of_line && phase >= slcp_pkg::PH_DONE_NO |=> $stable(phase))
    else $error("settled verdict changed before end of line");
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.line_kind != slcp_pkg::KIND_KEY |-> res.key_state == 8'd0)
    else $error("key byte set on a non-key line");
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.line_kind == slcp_pkg::KIND_CMD) ==
                  (res.command_code != slcp_pkg::CMD_NONE))
    else $error("command code does not agree with line kind");

endmodule

// ===== hw/rtl/slcp_out_buf.sv =====
// Serial line command parser: two-entry result register with skid stage.
// Depends on slcp_pkg.
module slcp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slcp_pkg::result_t push_data,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output slcp_pkg::result_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  slcp_pkg::result_t main_data;
  slcp_pkg::result_t skid_data;

  assign can_take  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held with empty output register");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into full buffer");
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> main_valid && !skid_valid)
    else $error("skid entry not moved on");

endmodule
